// ===== src/urm_pkg.sv =====
package urm_pkg;

    typedef enum logic [2:0] {
        FUNC_READ  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_RX    = 3'd2,
        FUNC_MODEM = 3'd3,
        FUNC_TICK  = 3'd4
    } urm_func_t;

    localparam logic [2:0] OFF_DATA  = 3'd0;
    localparam logic [2:0] OFF_IER   = 3'd1;
    localparam logic [2:0] OFF_IIR   = 3'd2;
    localparam logic [2:0] OFF_LCR   = 3'd3;
    localparam logic [2:0] OFF_MCR   = 3'd4;
    localparam logic [2:0] OFF_LSR   = 3'd5;
    localparam logic [2:0] OFF_MSR   = 3'd6;
    localparam logic [2:0] OFF_SCR   = 3'd7;

    localparam logic [7:0] IIR_RLS   = 8'h06;
    localparam logic [7:0] IIR_RDA   = 8'h04;
    localparam logic [7:0] IIR_THRE  = 8'h02;
    localparam logic [7:0] IIR_MS    = 8'h00;
    localparam logic [7:0] IIR_NONE  = 8'h01;
    localparam logic [7:0] READ_OPEN = 8'hFF;

    localparam int INT_RDA  = 0;
    localparam int INT_THRE = 1;
    localparam int INT_RLS  = 2;
    localparam int INT_MS   = 3;

    localparam int LS_DR    = 0;
    localparam int LS_THRE  = 5;

    localparam int MCR_LOOP = 4;
    localparam int LCR_DLAB = 7;

    localparam logic [6:0]  LSR_RESET   = 7'h60;
    localparam logic [3:0]  DELTA_LEVEL = 4'b1011;
    localparam logic [19:0] DELAY_RESET = 20'd100000;

    localparam logic [2:0] PAR_NONE  = 3'd0;
    localparam logic [2:0] PAR_ODD   = 3'd1;
    localparam logic [2:0] PAR_EVEN  = 3'd2;
    localparam logic [2:0] PAR_MARK  = 3'd3;
    localparam logic [2:0] PAR_SPACE = 3'd4;

    localparam logic [1:0] STOP_ONE  = 2'd0;
    localparam logic [1:0] STOP_HALF = 2'd1;
    localparam logic [1:0] STOP_TWO  = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
        logic       line_cts;
        logic       line_dsr;
        logic       line_dcd;
        logic       line_ri;
    } urm_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       dtr_out;
        logic       rts_out;
        logic       out1_out;
        logic       out2_out;
        logic [3:0] frame_data_bits;
        logic [2:0] parity_mode;
        logic [1:0] stop_mode;
    } urm_result_t;

endpackage

// ===== src/urm_core.sv =====
module urm_core #(
    parameter int COUNTDOWN_BITS = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [19:0]          cfg_wdata,
    input  logic                 step_en,
    input  urm_pkg::urm_item_t   item,
    output urm_pkg::urm_result_t result
);
    import urm_pkg::*;

    logic [19:0]               delay_reg;
    logic [3:0]                ier_reg, ier_next;
    logic [7:0]                lcr_reg, lcr_next;
    logic [4:0]                mcr_reg, mcr_next;
    logic [6:0]                lsr_reg, lsr_next;
    logic [3:0]                min_reg, min_next;
    logic [3:0]                last_reg, last_next;
    logic [3:0]                delta_reg, delta_next;
    logic [3:0]                pend_reg, pend_next;
    logic [15:0]               div_reg, div_next;
    logic [7:0]                rbr_reg, rbr_next;
    logic [7:0]                thr_reg, thr_next;
    logic [COUNTDOWN_BITS-1:0] cnt_reg, cnt_next;

    logic [COUNTDOWN_BITS-1:0] cnt_load;
    logic [3:0]                lines;
    logic [3:0]                changed;
    logic                      dlab;
    logic [7:0]                rd;
    logic                      txv;
    logic [7:0]                txb;

    assign cnt_load = COUNTDOWN_BITS'(delay_reg);
    assign dlab     = lcr_reg[LCR_DLAB];
    assign lines    = mcr_reg[MCR_LOOP] ? {mcr_reg[3], mcr_reg[2], mcr_reg[0], mcr_reg[1]}
                                        : min_reg;

    always_comb begin
        ier_next   = ier_reg;
        lcr_next   = lcr_reg;
        mcr_next   = mcr_reg;
        lsr_next   = lsr_reg;
        min_next   = min_reg;
        last_next  = last_reg;
        delta_next = delta_reg;
        pend_next  = pend_reg;
        div_next   = div_reg;
        rbr_next   = rbr_reg;
        thr_next   = thr_reg;
        cnt_next   = cnt_reg;
        rd         = 8'd0;
        txv        = 1'b0;
        txb        = 8'd0;
        changed    = (last_reg ^ lines) & DELTA_LEVEL;
        changed[INT_RLS] = last_reg[2] & ~lines[2];
        case (item.func)
            FUNC_READ: begin
                case (item.reg_offset)
                    OFF_DATA: begin
                        if (dlab) begin
                            rd = div_reg[7:0];
                        end else begin
                            pend_next[INT_RDA] = 1'b0;
                            lsr_next[LS_DR]    = 1'b0;
                            rd = rbr_reg;
                        end
                    end
                    OFF_IER: rd = dlab ? div_reg[15:8] : {4'd0, ier_reg};
                    OFF_IIR: begin
                        if (pend_reg[INT_RLS]) begin
                            rd = IIR_RLS;
                        end else if (pend_reg[INT_RDA]) begin
                            rd = IIR_RDA;
                        end else if (pend_reg[INT_THRE]) begin
                            pend_next[INT_THRE] = 1'b0;
                            rd = IIR_THRE;
                        end else if (pend_reg[INT_MS]) begin
                            rd = IIR_MS;
                        end else begin
                            rd = IIR_NONE;
                        end
                    end
                    OFF_LCR: rd = lcr_reg;
                    OFF_MCR: rd = {3'd0, mcr_reg};
                    OFF_LSR: begin
                        pend_next[INT_RLS] = 1'b0;
                        rd = {1'b0, lsr_reg};
                        lsr_next[4:1] = 4'd0;
                    end
                    OFF_MSR: begin
                        pend_next[INT_MS] = 1'b0;
                        rd = {lines, delta_reg};
                        last_next  = lines;
                        delta_next = 4'd0;
                    end
                    default: rd = READ_OPEN;
                endcase
            end
            FUNC_WRITE: begin
                case (item.reg_offset)
                    OFF_DATA: begin
                        if (dlab) begin
                            div_next[7:0] = item.write_data;
                        end else begin
                            pend_next[INT_THRE] = 1'b0;
                            lsr_next[LS_THRE]   = 1'b0;
                            thr_next = item.write_data;
                            cnt_next = cnt_load;
                        end
                    end
                    OFF_IER: begin
                        if (dlab) begin
                            div_next[15:8] = item.write_data;
                        end else begin
                            ier_next = item.write_data[3:0];
                        end
                    end
                    OFF_LCR: lcr_next = item.write_data;
                    OFF_MCR: mcr_next = item.write_data[4:0];
                    OFF_LSR: begin
                        lsr_next  = item.write_data[6:0];
                        pend_next = {pend_reg[INT_MS], |item.write_data[4:1],
                                     item.write_data[5], item.write_data[0]};
                    end
                    OFF_MSR: delta_next = item.write_data[3:0];
                    default: ;
                endcase
            end
            FUNC_RX: begin
                rbr_next           = item.rx_byte;
                lsr_next[LS_DR]    = 1'b1;
                pend_next[INT_RDA] = 1'b1;
            end
            FUNC_MODEM: begin
                if (!mcr_reg[MCR_LOOP]) begin
                    min_next = {item.line_dcd, item.line_ri, item.line_dsr, item.line_cts};
                end
            end
            FUNC_TICK: begin
                delta_next = delta_reg | changed;
                if (|delta_next) begin
                    pend_next[INT_MS] = 1'b1;
                end
                if (!lsr_reg[LS_THRE]) begin
                    if (mcr_reg[MCR_LOOP]) begin
                        rbr_next            = thr_reg;
                        lsr_next[LS_DR]     = 1'b1;
                        lsr_next[LS_THRE]   = 1'b1;
                        pend_next[INT_RDA]  = 1'b1;
                        pend_next[INT_THRE] = 1'b1;
                    end else if (cnt_reg <= COUNTDOWN_BITS'(1)) begin
                        cnt_next            = '0;
                        lsr_next[LS_THRE]   = 1'b1;
                        pend_next[INT_THRE] = 1'b1;
                        txv = 1'b1;
                        txb = thr_reg;
                    end else begin
                        cnt_next = cnt_reg - COUNTDOWN_BITS'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result.read_data       = rd;
        result.irq             = |(pend_next & ier_next);
        result.tx_valid        = txv;
        result.tx_byte         = txb;
        result.dtr_out         = mcr_next[0];
        result.rts_out         = mcr_next[1];
        result.out1_out        = mcr_next[2];
        result.out2_out        = mcr_next[3];
        result.frame_data_bits = {2'd0, lcr_next[1:0]} + 4'd5;
        if (!lcr_next[3]) begin
            result.parity_mode = PAR_NONE;
        end else if (lcr_next[5]) begin
            result.parity_mode = lcr_next[4] ? PAR_SPACE : PAR_MARK;
        end else begin
            result.parity_mode = lcr_next[4] ? PAR_EVEN : PAR_ODD;
        end
        if (!lcr_next[2]) begin
            result.stop_mode = STOP_ONE;
        end else begin
            result.stop_mode = (lcr_next[1:0] == 2'd0) ? STOP_HALF : STOP_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
            ier_reg   <= '0;
            lcr_reg   <= '0;
            mcr_reg   <= '0;
            lsr_reg   <= LSR_RESET;
            min_reg   <= '0;
            last_reg  <= '0;
            delta_reg <= '0;
            pend_reg  <= '0;
            div_reg   <= '0;
            rbr_reg   <= '0;
            thr_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                delay_reg <= cfg_wdata;
            end
            if (step_en) begin
                ier_reg   <= ier_next;
                lcr_reg   <= lcr_next;
                mcr_reg   <= mcr_next;
                lsr_reg   <= lsr_next;
                min_reg   <= min_next;
                last_reg  <= last_next;
                delta_reg <= delta_next;
                pend_reg  <= pend_next;
                div_reg   <= div_next;
                rbr_reg   <= rbr_next;
                thr_reg   <= thr_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    a_thre_clears_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.func == FUNC_WRITE && item.reg_offset == OFF_DATA && !dlab
        |=> !lsr_reg[LS_THRE] && cnt_reg == $past(cnt_load))
        else $error("transmit load did not arm the countdown");

    a_tx_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        txv |-> !lsr_reg[LS_THRE] && !mcr_reg[MCR_LOOP])
        else $error("byte sent while holding register empty or in loopback");

    a_msr_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.func == FUNC_READ && item.reg_offset == OFF_MSR
        |=> delta_reg == 4'd0 && !pend_reg[INT_MS])
        else $error("modem status read left deltas pending");

endmodule

// ===== src/uart_register_model.sv =====
// Register-level model of an 8250-style UART. Each accepted item is a bus read, a bus
// write, a received byte, new modem input levels or a tick (other function codes
// change no state), and yields exactly one result item holding the read data, the
// interrupt line, any byte sent on that tick and the decoded line and modem control
// settings. One item is taken per clock while m_ready stays high: the item is
// captured in an input register, the register file updates in a single pass and the
// result lands in an output register. cfg_wdata sets the transmit delay in ticks
// and must be written while no item is in flight.
module uart_register_model #(
    parameter int COUNTDOWN_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [2:0]  s_reg_offset,
    input  logic [7:0]  s_write_data,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_line_cts,
    input  logic        s_line_dsr,
    input  logic        s_line_dcd,
    input  logic        s_line_ri,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_irq,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_dtr_out,
    output logic        m_rts_out,
    output logic        m_out1_out,
    output logic        m_out2_out,
    output logic [3:0]  m_frame_data_bits,
    output logic [2:0]  m_parity_mode,
    output logic [1:0]  m_stop_mode
);
    import urm_pkg::*;

    logic        in_valid_reg;
    urm_item_t   in_item_reg;
    logic        out_valid_reg;
    urm_result_t out_result_reg;
    urm_result_t core_result;
    logic        advance;
    logic        step_en;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step_en = in_valid_reg && advance;

    urm_core #(
        .COUNTDOWN_BITS(COUNTDOWN_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .step_en  (step_en),
        .item     (in_item_reg),
        .result   (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{func: s_func, reg_offset: s_reg_offset,
                             write_data: s_write_data, rx_byte: s_rx_byte,
                             line_cts: s_line_cts, line_dsr: s_line_dsr,
                             line_dcd: s_line_dcd, line_ri: s_line_ri};
        end
        if (step_en) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_read_data       = out_result_reg.read_data;
    assign m_irq             = out_result_reg.irq;
    assign m_tx_valid        = out_result_reg.tx_valid;
    assign m_tx_byte         = out_result_reg.tx_byte;
    assign m_dtr_out         = out_result_reg.dtr_out;
    assign m_rts_out         = out_result_reg.rts_out;
    assign m_out1_out        = out_result_reg.out1_out;
    assign m_out2_out        = out_result_reg.out2_out;
    assign m_frame_data_bits = out_result_reg.frame_data_bits;
    assign m_parity_mode     = out_result_reg.parity_mode;
    assign m_stop_mode       = out_result_reg.stop_mode;

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("processed item did not reach the output register");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_tx_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid |-> m_read_data == 8'd0)
        else $error("tick result carries read data");

    a_frame_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_data_bits >= 4'd5 && m_parity_mode <= PAR_SPACE
                    && m_stop_mode <= STOP_TWO)
        else $error("line control decode out of range");

endmodule

// ===== dv/uart_register_model_tb.sv =====
`timescale 1ns / 100ps

module uart_register_model_tb;

    import urm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT = 330;
    localparam int HOLD_CYCLES = 200;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam int LCR_STB = 2;
    localparam int LCR_PEN = 3;
    localparam int LCR_EPS = 4;
    localparam int LCR_STICK = 5;
    localparam int LINE_RI = 2;
    localparam logic [6:0] LSR_ERR_BITS = 7'h1E;

    typedef struct {
        urm_item_t  item;
        bit         typed;
        logic [7:0] read_data;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [19:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [2:0]  s_reg_offset;
    logic [7:0]  s_write_data;
    logic [7:0]  s_rx_byte;
    logic        s_line_cts;
    logic        s_line_dsr;
    logic        s_line_dcd;
    logic        s_line_ri;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_irq;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_dtr_out;
    logic        m_rts_out;
    logic        m_out1_out;
    logic        m_out2_out;
    logic [3:0]  m_frame_data_bits;
    logic [2:0]  m_parity_mode;
    logic [1:0]  m_stop_mode;

    // predictor state
    logic [19:0] tx_delay_q;
    logic [3:0]  ier_q;
    logic [7:0]  lcr_q;
    logic [4:0]  mcr_q;
    logic [6:0]  lsr_q;
    logic [3:0]  msr_in_q;
    logic [3:0]  msr_last_q;
    logic [3:0]  msr_delta_q;
    logic [3:0]  int_pend_q;
    logic [15:0] dl_q;
    logic [7:0]  rbr_q;
    logic [7:0]  thr_q;
    logic [19:0] tx_count_q;

    urm_result_t due_responses[$];
    script_row_t script_rows[$];
    int          err_count = 0;
    int          accepted_count = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          irq_seen = 0;
    int          delay_settings = 0;
    bit          steady_feed = 1'b0;
    bit          held_off = 1'b0;

    uart_register_model dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_reg_offset      (s_reg_offset),
        .s_write_data      (s_write_data),
        .s_rx_byte         (s_rx_byte),
        .s_line_cts        (s_line_cts),
        .s_line_dsr        (s_line_dsr),
        .s_line_dcd        (s_line_dcd),
        .s_line_ri         (s_line_ri),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_irq             (m_irq),
        .m_tx_valid        (m_tx_valid),
        .m_tx_byte         (m_tx_byte),
        .m_dtr_out         (m_dtr_out),
        .m_rts_out         (m_rts_out),
        .m_out1_out        (m_out1_out),
        .m_out2_out        (m_out2_out),
        .m_frame_data_bits (m_frame_data_bits),
        .m_parity_mode     (m_parity_mode),
        .m_stop_mode       (m_stop_mode)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    task automatic reset_model();
        tx_delay_q = DELAY_RESET;
        ier_q = '0;
        lcr_q = '0;
        mcr_q = '0;
        lsr_q = LSR_RESET;
        msr_in_q = '0;
        msr_last_q = '0;
        msr_delta_q = '0;
        int_pend_q = '0;
        dl_q = '0;
        rbr_q = '0;
        thr_q = '0;
        tx_count_q = '0;
    endtask

    function automatic logic [3:0] modem_levels();
        if (mcr_q[MCR_LOOP]) return {mcr_q[3], mcr_q[2], mcr_q[0], mcr_q[1]};
        return msr_in_q;
    endfunction

    function automatic logic [7:0] uart_read(input logic [2:0] off);
        logic       dlab;
        logic [3:0] lv;
        logic [7:0] rd;
        dlab = lcr_q[LCR_DLAB];
        rd = READ_OPEN;
        case (off)
            OFF_DATA: begin
                if (dlab) begin
                    rd = dl_q[7:0];
                end else begin
                    int_pend_q[INT_RDA] = 1'b0;
                    lsr_q[LS_DR] = 1'b0;
                    rd = rbr_q;
                end
            end
            OFF_IER: rd = dlab ? dl_q[15:8] : {4'd0, ier_q};
            OFF_IIR: begin
                if (int_pend_q[INT_RLS]) rd = IIR_RLS;
                else if (int_pend_q[INT_RDA]) rd = IIR_RDA;
                else if (int_pend_q[INT_THRE]) begin
                    int_pend_q[INT_THRE] = 1'b0;
                    rd = IIR_THRE;
                end
                else if (int_pend_q[INT_MS]) rd = IIR_MS;
                else rd = IIR_NONE;
            end
            OFF_LCR: rd = lcr_q;
            OFF_MCR: rd = {3'd0, mcr_q};
            OFF_LSR: begin
                int_pend_q[INT_RLS] = 1'b0;
                rd = {1'b0, lsr_q};
                lsr_q = lsr_q & ~LSR_ERR_BITS;
            end
            OFF_MSR: begin
                int_pend_q[INT_MS] = 1'b0;
                lv = modem_levels();
                rd = {lv, msr_delta_q};
                msr_last_q = lv;
                msr_delta_q = '0;
            end
            default: rd = READ_OPEN;
        endcase
        return rd;
    endfunction

    function automatic void uart_write(input logic [2:0] off, input logic [7:0] v);
        logic dlab;
        dlab = lcr_q[LCR_DLAB];
        case (off)
            OFF_DATA: begin
                if (dlab) begin
                    dl_q[7:0] = v;
                end else begin
                    int_pend_q[INT_THRE] = 1'b0;
                    lsr_q[LS_THRE] = 1'b0;
                    thr_q = v;
                    tx_count_q = tx_delay_q;
                end
            end
            OFF_IER: begin
                if (dlab) dl_q[15:8] = v;
                else ier_q = v[3:0];
            end
            OFF_LCR: lcr_q = v;
            OFF_MCR: mcr_q = v[4:0];
            OFF_LSR: begin
                lsr_q = v[6:0];
                int_pend_q[INT_RDA] = v[LS_DR];
                int_pend_q[INT_THRE] = v[LS_THRE];
                int_pend_q[INT_RLS] = |(v[6:0] & LSR_ERR_BITS);
            end
            OFF_MSR: msr_delta_q = v[3:0];
            default: ;
        endcase
    endfunction

    function automatic bit uart_tick(output logic [7:0] sent);
        logic [3:0] lv;
        logic [3:0] chg;
        sent = 8'd0;
        lv = modem_levels();
        chg = (msr_last_q ^ lv) & DELTA_LEVEL;
        if (msr_last_q[LINE_RI] && !lv[LINE_RI]) chg[LINE_RI] = 1'b1;
        msr_delta_q = msr_delta_q | chg;
        if (msr_delta_q != 4'd0) int_pend_q[INT_MS] = 1'b1;
        if (lsr_q[LS_THRE]) return 1'b0;
        if (mcr_q[MCR_LOOP]) begin
            rbr_q = thr_q;
            lsr_q[LS_DR] = 1'b1;
            lsr_q[LS_THRE] = 1'b1;
            int_pend_q[INT_RDA] = 1'b1;
            int_pend_q[INT_THRE] = 1'b1;
            return 1'b0;
        end
        if (tx_count_q <= 20'd1) begin
            tx_count_q = '0;
            lsr_q[LS_THRE] = 1'b1;
            int_pend_q[INT_THRE] = 1'b1;
            sent = thr_q;
            return 1'b1;
        end
        tx_count_q = tx_count_q - 20'd1;
        return 1'b0;
    endfunction

    function automatic urm_result_t uart_response(input urm_item_t it);
        urm_result_t res;
        logic [7:0]  sent;
        res = '0;
        case (it.func)
            FUNC_READ: res.read_data = uart_read(it.reg_offset);
            FUNC_WRITE: uart_write(it.reg_offset, it.write_data);
            FUNC_RX: begin
                rbr_q = it.rx_byte;
                lsr_q[LS_DR] = 1'b1;
                int_pend_q[INT_RDA] = 1'b1;
            end
            FUNC_MODEM: begin
                if (!mcr_q[MCR_LOOP])
                    msr_in_q = {it.line_dcd, it.line_ri, it.line_dsr, it.line_cts};
            end
            FUNC_TICK: begin
                res.tx_valid = uart_tick(sent);
                res.tx_byte = sent;
            end
            default: ;
        endcase
        res.irq = |(int_pend_q & ier_q);
        res.dtr_out = mcr_q[0];
        res.rts_out = mcr_q[1];
        res.out1_out = mcr_q[2];
        res.out2_out = mcr_q[3];
        res.frame_data_bits = 4'd5 + {2'b00, lcr_q[1:0]};
        if (!lcr_q[LCR_PEN]) res.parity_mode = PAR_NONE;
        else if (lcr_q[LCR_STICK]) res.parity_mode = lcr_q[LCR_EPS] ? PAR_SPACE : PAR_MARK;
        else res.parity_mode = lcr_q[LCR_EPS] ? PAR_EVEN : PAR_ODD;
        if (!lcr_q[LCR_STB]) res.stop_mode = STOP_ONE;
        else res.stop_mode = (lcr_q[1:0] == 2'b00) ? STOP_HALF : STOP_TWO;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic urm_item_t random_item();
        urm_item_t it;
        int        pick;
        it.func = FUNC_TICK;
        it.reg_offset = 3'($urandom_range(0, 7));
        it.write_data = 8'($urandom_range(0, 255));
        it.rx_byte = 8'($urandom_range(0, 255));
        it.line_cts = 1'($urandom_range(0, 1));
        it.line_dsr = 1'($urandom_range(0, 1));
        it.line_dcd = 1'($urandom_range(0, 1));
        it.line_ri = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            it.func = FUNC_READ;
        end else if (pick < 52) begin
            it.func = FUNC_WRITE;
            case ($urandom_range(0, 5))
                0: it.reg_offset = OFF_DATA;
                1: begin
                    it.reg_offset = OFF_LCR;
                    it.write_data[LCR_DLAB] = ($urandom_range(0, 3) == 0);
                end
                2: begin
                    it.reg_offset = OFF_MCR;
                    it.write_data[MCR_LOOP] = ($urandom_range(0, 2) == 0);
                end
                3: it.reg_offset = OFF_IER;
                default: ;
            endcase
        end else if (pick < 62) begin
            it.func = FUNC_RX;
        end else if (pick < 72) begin
            it.func = FUNC_MODEM;
        end else if (pick < 99) begin
            it.func = FUNC_TICK;
        end else begin
            it.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
        end
        return it;
    endfunction

    task automatic add_row(input logic [2:0] fn, input logic [2:0] off, input logic [7:0] data,
                           input bit typed, input logic [7:0] rd);
        script_row_t row;
        row.item.func = fn;
        row.item.reg_offset = off;
        row.item.write_data = data;
        row.item.rx_byte = data;
        row.item.line_cts = data[0];
        row.item.line_dsr = data[1];
        row.item.line_ri = data[2];
        row.item.line_dcd = data[3];
        row.typed = typed;
        row.read_data = rd;
        script_rows.push_back(row);
    endtask

    task automatic set_tx_delay(input logic [19:0] ticks);
        cfg_we = 1'b1;
        cfg_wdata = ticks;
        @(negedge aclk);
        cfg_we = 1'b0;
        tx_delay_q = ticks;
        delay_settings++;
    endtask

    task automatic drain_responses();
        s_valid = 1'b0;
        while (due_responses.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_item(input urm_item_t it, input bit typed, input logic [7:0] typed_rd);
        urm_result_t want;
        int          gap;
        if ($urandom_range(0, 31) == 0) steady_feed = !steady_feed;
        gap = steady_feed ? 0 : idle_len();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_func = it.func;
        s_reg_offset = it.reg_offset;
        s_write_data = it.write_data;
        s_rx_byte = it.rx_byte;
        s_line_cts = it.line_cts;
        s_line_dsr = it.line_dsr;
        s_line_dcd = it.line_dcd;
        s_line_ri = it.line_ri;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        want = uart_response(it);
        if (typed) want.read_data = typed_rd;
        due_responses.push_back(want);
        accepted_count++;
        @(negedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : response_check
        urm_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_responses.size() == 0) begin
                err_count++;
                $display("%0t: result item with nothing expected, read_data %0h",
                         $time, m_read_data);
            end else begin
                want = due_responses.pop_front();
                compare_field("read_data", want.read_data, m_read_data);
                compare_field("irq", 8'(want.irq), 8'(m_irq));
                compare_field("tx_valid", 8'(want.tx_valid), 8'(m_tx_valid));
                compare_field("tx_byte", want.tx_byte, m_tx_byte);
                compare_field("dtr_out", 8'(want.dtr_out), 8'(m_dtr_out));
                compare_field("rts_out", 8'(want.rts_out), 8'(m_rts_out));
                compare_field("out1_out", 8'(want.out1_out), 8'(m_out1_out));
                compare_field("out2_out", 8'(want.out2_out), 8'(m_out2_out));
                compare_field("frame_data_bits", 8'(want.frame_data_bits),
                              8'(m_frame_data_bits));
                compare_field("parity_mode", 8'(want.parity_mode), 8'(m_parity_mode));
                compare_field("stop_mode", 8'(want.stop_mode), 8'(m_stop_mode));
                if (m_tx_valid === 1'b1) bytes_sent++;
                if (m_irq === 1'b1) irq_seen++;
            end
        end
    end

    initial begin : sink
        int hold_left;
        int stall_left;
        int run_left;
        hold_left = 0;
        stall_left = 0;
        run_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && !held_off && accepted_count >= HOLD_AT) begin
                held_off = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left == 0 && stall_left == 0 && run_left == 0) begin
                stall_left = idle_len();
                run_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else begin
                run_left--;
                m_ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("uart_register_model_tb: errors");
        $finish;
    end

    initial begin : stimulus
        logic [19:0] delays [5];
        int          counts [5];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_func = FUNC_READ;
        s_reg_offset = OFF_DATA;
        s_write_data = '0;
        s_rx_byte = '0;
        s_line_cts = 1'b0;
        s_line_dsr = 1'b0;
        s_line_dcd = 1'b0;
        s_line_ri = 1'b0;
        reset_model();

        add_row(FUNC_READ, OFF_IIR, 8'h00, 1'b1, IIR_NONE);
        add_row(FUNC_READ, OFF_LSR, 8'h00, 1'b1, {1'b0, LSR_RESET});
        add_row(FUNC_READ, OFF_SCR, 8'h00, 1'b1, READ_OPEN);
        add_row(FUNC_WRITE, OFF_LCR, 8'hFF, 1'b0, 8'h00);
        add_row(FUNC_WRITE, OFF_DATA, 8'hFF, 1'b0, 8'h00);
        add_row(FUNC_READ, OFF_DATA, 8'h00, 1'b1, 8'hFF);
        add_row(FUNC_WRITE, OFF_LCR, 8'h03, 1'b0, 8'h00);
        add_row(FUNC_WRITE, OFF_IIR, 8'hFF, 1'b0, 8'h00);
        add_row(FUNC_WRITE, OFF_SCR, 8'hFF, 1'b0, 8'h00);
        add_row(FUNC_WRITE, OFF_DATA, 8'hFF, 1'b0, 8'h00);
        add_row(FUNC_TICK, OFF_DATA, 8'h00, 1'b0, 8'h00);
        add_row(FUNC_READ, OFF_IIR, 8'h00, 1'b1, IIR_THRE);
        add_row(FUNC_RX, OFF_DATA, 8'hFF, 1'b0, 8'h00);
        add_row(FUNC_READ, OFF_IIR, 8'h00, 1'b1, IIR_RDA);
        add_row(FUNC_READ, OFF_DATA, 8'h00, 1'b1, 8'hFF);
        add_row(FUNC_WRITE, OFF_LSR, 8'h1E, 1'b0, 8'h00);
        add_row(FUNC_READ, OFF_IIR, 8'h00, 1'b1, IIR_RLS);
        add_row(FUNC_TICK, OFF_DATA, 8'h00, 1'b0, 8'h00);
        add_row(FUNC_MODEM, OFF_DATA, 8'h0F, 1'b0, 8'h00);
        add_row(FUNC_TICK, OFF_DATA, 8'h00, 1'b0, 8'h00);
        add_row(FUNC_READ, OFF_MSR, 8'h00, 1'b1, 8'hFB);
        add_row(FUNC_WRITE, OFF_MSR, 8'h0F, 1'b0, 8'h00);
        add_row(FUNC_WRITE, OFF_MCR, 8'h1F, 1'b0, 8'h00);
        add_row(FUNC_MODEM, OFF_DATA, 8'h00, 1'b0, 8'h00);
        add_row(FUNC_WRITE, OFF_DATA, 8'h5A, 1'b0, 8'h00);
        add_row(FUNC_TICK, OFF_DATA, 8'h00, 1'b0, 8'h00);
        add_row(FUNC_READ, OFF_DATA, 8'h00, 1'b1, 8'h5A);
        add_row(FUNC_SPARE_LO, OFF_DATA, 8'hFF, 1'b0, 8'h00);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_tx_delay(20'd1);
        foreach (script_rows[i])
            send_item(script_rows[i].item, script_rows[i].typed, script_rows[i].read_data);

        delays = '{20'd1, 20'hFFFFF, 20'd3, DELAY_RESET, 20'($urandom_range(2, 6))};
        counts = '{250, 120, 250, 120, 260};
        for (int p = 0; p < 5; p++) begin
            drain_responses();
            set_tx_delay(delays[p]);
            repeat (counts[p]) send_item(random_item(), 1'b0, 8'h00);
        end
        drain_responses();
        repeat (8) @(posedge aclk);

        $display("Ran %0d items under %0d transmit delay settings, one long sink stall.",
                 accepted_count, delay_settings);
        $display("Saw %0d bytes leave the transmitter and %0d results with irq high.",
                 bytes_sent, irq_seen);
        if (err_count == 0) begin
            $display("uart_register_model_tb: clean");
        end else begin
            $display("uart_register_model_tb: errors");
        end
        $finish;
    end

endmodule

// ===== uart_register_model.f =====
src/urm_pkg.sv
src/urm_core.sv
src/uart_register_model.sv
dv/uart_register_model_tb.sv
